### sv/fis_pkg.sv
`default_nettype none
package fis_pkg;

  localparam int TS_W       = 32;
  localparam int INTERVAL_W = 24;
  localparam int RATE_W     = 28;
  localparam int WIN_W      = 9;
  // n * (2^24 - 1) with n below 512
  localparam int SUM_W      = 33;
  // n * 256 * 10^6 with n below 512
  localparam int NUM_W      = 37;
  localparam int DIV_CNT_W  = 6;

  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = {INTERVAL_W{1'b1}};
  localparam logic [RATE_W-1:0]     RATE_MAX     = {RATE_W{1'b1}};
  localparam logic [RATE_W-1:0]     RATE_SCALE   = 28'd256000000;
  localparam logic [WIN_W-1:0]      WINDOW_RESET = 9'd60;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WALK = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

### sv/frame_interval_stats.sv
// Sequence per request: a walk of all F intervals held in the ring, one multiply,
//   a 38-step divide, then the output register is loaded. The divide is skipped
//   when the window sum is zero; the first event goes straight to output. Results stall until m_tready.
// Throughput: one event in flight at a time; a new event is taken only when idle.
// Reset (rst, synchronous): no previous time, ring empty, window 60. Ring contents
//   are not cleared; only written entries are read.
`default_nettype none
module frame_interval_stats #(
  parameter int RING_DEPTH = 360
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] timestamp_us
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [27:0] rate_q8, [51:28] worst_interval_us,
                                      // [60:52] intervals_averaged, [63:61] zero
  output logic             m_tuser    // [0] stats_valid
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int CMP_W = (CNT_W > fis_pkg::WIN_W) ? CNT_W : fis_pkg::WIN_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
  localparam logic [CMP_W-1:0] CMP_FULL = CMP_W'(RING_DEPTH);

  fis_pkg::state_t state;

  logic [fis_pkg::WIN_W-1:0]      average_window;
  logic [fis_pkg::TS_W-1:0]       previous_time;
  logic                           have_previous;
  logic [PTR_W-1:0]               write_position;
  logic [CNT_W-1:0]               filled_count;

  logic [fis_pkg::INTERVAL_W-1:0] ring [RING_DEPTH];
  logic [fis_pkg::INTERVAL_W-1:0] rd_data;
  logic [PTR_W-1:0]               rd_ptr;
  logic                           ring_we;
  logic [fis_pkg::INTERVAL_W-1:0] ring_wdata;

  logic [CNT_W-1:0]               issue_cnt;
  logic                           pend;
  logic                           pend_win;
  logic [fis_pkg::WIN_W-1:0]      n_avg;
  logic [fis_pkg::SUM_W-1:0]      sum_acc;
  logic [fis_pkg::INTERVAL_W-1:0] worst_acc;
  logic [fis_pkg::NUM_W-1:0]      num;
  logic [fis_pkg::SUM_W-1:0]      rem;
  logic [fis_pkg::DIV_CNT_W-1:0]  div_cnt;
  logic [fis_pkg::RATE_W-1:0]     rate;
  logic                           first_evt;

  logic                           accept;
  logic [fis_pkg::TS_W-1:0]       dt_full;
  logic [fis_pkg::INTERVAL_W-1:0] dt_sat;
  logic [CNT_W-1:0]               filled_next;
  logic [CMP_W-1:0]               win_eff;
  logic [CMP_W-1:0]               n_next;
  logic [fis_pkg::SUM_W:0]        trial;
  logic                           trial_ge;

  assign s_tready = (state == fis_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    dt_full     = s_tdata - previous_time;
    dt_sat      = (dt_full > fis_pkg::TS_W'(fis_pkg::INTERVAL_MAX)) ?
                  fis_pkg::INTERVAL_MAX : dt_full[fis_pkg::INTERVAL_W-1:0];
    filled_next = (filled_count < CNT_FULL) ? filled_count + 1'b1 : filled_count;
    win_eff     = CMP_W'(average_window);
    if (win_eff == '0) win_eff = CMP_W'(1);
    if (win_eff > CMP_FULL) win_eff = CMP_FULL;
    n_next      = (win_eff > CMP_W'(filled_next)) ? CMP_W'(filled_next) : win_eff;
    ring_we     = accept && have_previous;
    ring_wdata  = dt_sat;
    // one restoring-divide step: trial remainder and compare
    trial       = {rem, num[fis_pkg::NUM_W-1]};
    trial_ge    = trial >= {1'b0, sum_acc};
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring[write_position] <= ring_wdata;
    rd_data <= ring[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) average_window <= fis_pkg::WINDOW_RESET;
    else if (cfg_we) average_window <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= fis_pkg::ST_IDLE;
      have_previous  <= 1'b0;
      previous_time  <= '0;
      write_position <= '0;
      filled_count   <= '0;
      pend           <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // in ST_FIN the output register is refilled instead
      if (m_tvalid && m_tready && state != fis_pkg::ST_FIN) m_tvalid <= 1'b0;
      case (state)
        fis_pkg::ST_IDLE: begin
          if (accept) begin
            previous_time <= s_tdata;
            have_previous <= 1'b1;
            first_evt     <= !have_previous;
            if (!have_previous) begin
              state <= fis_pkg::ST_FIN;
            end else begin
              write_position <= (write_position == PTR_LAST) ? '0 : write_position + 1'b1;
              filled_count   <= filled_next;
              n_avg          <= n_next[fis_pkg::WIN_W-1:0];
              rd_ptr         <= write_position;   // newest entry first
              issue_cnt      <= '0;
              pend           <= 1'b0;
              sum_acc        <= '0;
              worst_acc      <= '0;
              state          <= fis_pkg::ST_WALK;
            end
          end
        end
        fis_pkg::ST_WALK: begin
          if (issue_cnt != filled_count) begin
            pend      <= 1'b1;
            pend_win  <= CMP_W'(issue_cnt) < CMP_W'(n_avg);
            issue_cnt <= issue_cnt + 1'b1;
            rd_ptr    <= (rd_ptr == '0) ? PTR_LAST : rd_ptr - 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (pend_win) sum_acc <= sum_acc + fis_pkg::SUM_W'(rd_data);
            if (rd_data > worst_acc) worst_acc <= rd_data;
          end
          if (issue_cnt == filled_count && !pend) state <= fis_pkg::ST_MUL;
        end
        fis_pkg::ST_MUL: begin
          num     <= fis_pkg::NUM_W'(n_avg) * fis_pkg::NUM_W'(fis_pkg::RATE_SCALE);
          rem     <= '0;
          div_cnt <= '0;
          if (sum_acc == '0) begin
            rate  <= '0;
            state <= fis_pkg::ST_FIN;
          end else begin
            state <= fis_pkg::ST_DIV;
          end
        end
        fis_pkg::ST_DIV: begin
          // num shifts out the dividend and takes in quotient bits
          num     <= {num[fis_pkg::NUM_W-2:0], trial_ge};
          rem     <= trial_ge ? fis_pkg::SUM_W'(trial - {1'b0, sum_acc})
                              : trial[fis_pkg::SUM_W-1:0];
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == fis_pkg::DIV_CNT_W'(fis_pkg::NUM_W)) begin
            rate  <= (num > fis_pkg::NUM_W'(fis_pkg::RATE_MAX)) ?
                     fis_pkg::RATE_MAX : num[fis_pkg::RATE_W-1:0];
            state <= fis_pkg::ST_FIN;
          end
        end
        fis_pkg::ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (first_evt) begin
              m_tuser <= 1'b0;
              m_tdata <= '0;
            end else begin
              m_tuser <= 1'b1;
              m_tdata <= {3'b000, n_avg, worst_acc, rate};
            end
            state <= fis_pkg::ST_IDLE;
          end
        end
        default: state <= fis_pkg::ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
